// ===== src/pqs_pkg.sv =====
package pqs_pkg;

   typedef enum logic [1:0] {
      FN_ENQUEUE = 2'd0,
      FN_DEQUEUE = 2'd1,
      FN_PEEK    = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] value;
      logic [7:0]  prio;
   } entry_type;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   // microprogram addresses
   localparam upc_type U_IDLE     = 4'd0;
   localparam upc_type U_ENQ      = 4'd1;
   localparam upc_type U_SCAN0    = 4'd2;
   localparam upc_type U_SCAN     = 4'd3;
   localparam upc_type U_SCAN_END = 4'd4;
   localparam upc_type U_DQ_SETUP = 4'd5;
   localparam upc_type U_SHIFT0   = 4'd6;
   localparam upc_type U_SHIFT    = 4'd7;
   localparam upc_type U_DQ_END   = 4'd8;
   localparam upc_type U_RSP_BEST = 4'd9;
   localparam upc_type U_RSP_ZERO = 4'd10;
   localparam upc_type U_RSP_UNDR = 4'd11;
   localparam upc_type U_RSP_OVFL = 4'd12;

   typedef enum logic [2:0] {
      A_HOLD      = 3'd0,
      A_LAST      = 3'd1,
      A_DEC       = 3'd2,
      A_INC       = 3'd3,
      A_BEST_NEXT = 3'd4
   } addr_op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_ENQ   = 2'd1,
      WR_SHIFT = 2'd2
   } wr_op_type;

   typedef enum logic [1:0] {
      CMP_NONE = 2'd0,
      CMP_INIT = 2'd1,
      CMP_SCAN = 2'd2
   } cmp_op_type;

   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef enum logic [2:0] {
      RS_NONE = 3'd0,
      RS_BEST = 3'd1,
      RS_ZERO = 3'd2,
      RS_UNDR = 3'd3,
      RS_OVFL = 3'd4
   } rsp_sel_type;

   typedef enum logic [2:0] {
      C_NEXT      = 3'd0,
      C_ALWAYS    = 3'd1,
      C_DISPATCH  = 3'd2,
      C_IDX_NZERO = 3'd3,
      C_IDX_NLAST = 3'd4,
      C_PEEK      = 3'd5,
      C_BEST_LAST = 3'd6
   } cond_type;

   typedef struct packed {
      logic        accept;
      addr_op_type addr_op;
      wr_op_type   wr_op;
      cmp_op_type  cmp_op;
      cnt_op_type  cnt_op;
      rsp_sel_type rsp_sel;
      cond_type    cond;
      upc_type     target;
   } ctrl_type;

   typedef struct packed {
      logic       accept;
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       idx_zero;
      logic       idx_last;
      logic       best_last;
      logic       is_peek;
      logic       rsp_free;
   } flags_type;

   function automatic ctrl_type uword(logic acc, addr_op_type a, wr_op_type w, cmp_op_type c,
                                      cnt_op_type n, rsp_sel_type r, cond_type cd, upc_type t);
      ctrl_type cw;
      cw.accept  = acc;
      cw.addr_op = a;
      cw.wr_op   = w;
      cw.cmp_op  = c;
      cw.cnt_op  = n;
      cw.rsp_sel = r;
      cw.cond    = cd;
      cw.target  = t;
      return cw;
   endfunction

   // control store
   function automatic ctrl_type ucode(upc_type pc);
      ctrl_type cw;
      case (pc)
         U_IDLE:     cw = uword(1'b1, A_LAST, WR_NONE, CMP_NONE, CNT_NONE, RS_NONE,
                                C_DISPATCH, U_IDLE);
         U_ENQ:      cw = uword(1'b0, A_HOLD, WR_ENQ, CMP_NONE, CNT_INC, RS_NONE,
                                C_ALWAYS, U_RSP_ZERO);
         U_SCAN0:    cw = uword(1'b0, A_DEC, WR_NONE, CMP_INIT, CNT_NONE, RS_NONE,
                                C_NEXT, U_IDLE);
         U_SCAN:     cw = uword(1'b0, A_DEC, WR_NONE, CMP_SCAN, CNT_NONE, RS_NONE,
                                C_IDX_NZERO, U_SCAN);
         U_SCAN_END: cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_NONE,
                                C_PEEK, U_RSP_BEST);
         U_DQ_SETUP: cw = uword(1'b0, A_BEST_NEXT, WR_NONE, CMP_NONE, CNT_NONE, RS_NONE,
                                C_BEST_LAST, U_DQ_END);
         U_SHIFT0:   cw = uword(1'b0, A_INC, WR_NONE, CMP_NONE, CNT_NONE, RS_NONE,
                                C_NEXT, U_IDLE);
         U_SHIFT:    cw = uword(1'b0, A_INC, WR_SHIFT, CMP_NONE, CNT_NONE, RS_NONE,
                                C_IDX_NLAST, U_SHIFT);
         U_DQ_END:   cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_DEC, RS_NONE,
                                C_NEXT, U_IDLE);
         U_RSP_BEST: cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_BEST,
                                C_ALWAYS, U_IDLE);
         U_RSP_ZERO: cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_ZERO,
                                C_ALWAYS, U_IDLE);
         U_RSP_UNDR: cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_UNDR,
                                C_ALWAYS, U_IDLE);
         U_RSP_OVFL: cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_OVFL,
                                C_ALWAYS, U_IDLE);
         default:    cw = uword(1'b0, A_HOLD, WR_NONE, CMP_NONE, CNT_NONE, RS_NONE,
                                C_ALWAYS, U_IDLE);
      endcase
      return cw;
   endfunction

endpackage

// ===== src/pqs_req_if.sv =====
interface pqs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] item_value;
   logic [7:0]  item_priority;

   modport source (output valid, output func, output item_value, output item_priority,
                   input ready);
   modport sink (input valid, input func, input item_value, input item_priority,
                 output ready);
endinterface

// ===== src/pqs_rsp_if.sv =====
interface pqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_value;
   logic [7:0]  out_priority;

   modport source (output valid, output status, output out_value, output out_priority,
                   input ready);
   modport sink (input valid, input status, input out_value, input out_priority,
                 output ready);
endinterface

// ===== src/priority_queue_scan_core.sv =====
// channel  dir  handshake          payload
// req      in   valid/ready        func, item_value, item_priority
// rsp      out  valid/ready        status, out_value, out_priority
//
// One request at a time, all through the single-read-port entry RAM.
// Peek and dequeue scan from the newest entry; dequeue then closes the gap.
// Synchronous reset empties the queue; no clearing pass, slots are only read below the count.
// rsp is registered; a stalled rsp holds the sequencer on its answer step.
module priority_queue_scan_core import pqs_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   pqs_req_if.sink    req,
   pqs_rsp_if.source  rsp
);

   ctrl_type  ctrl;
   flags_type flags;
   logic      req_accept;

   assign req.ready  = ctrl.accept;
   assign req_accept = req.valid && ctrl.accept;

   pqs_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   pqs_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_accept        (req_accept),
      .req_func          (req.func),
      .req_item_value    (req.item_value),
      .req_item_priority (req.item_priority),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_status        (rsp.status),
      .rsp_out_value     (rsp.out_value),
      .rsp_out_priority  (rsp.out_priority),
      .flags             (flags)
   );

endmodule

// ===== src/pqs_ram.sv =====
module pqs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pqs_useq.sv =====
module pqs_useq import pqs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   upc_type upc_ff;
   upc_type upc_in;
   upc_type dispatch;
   logic    taken;
   logic    stall;

   assign ctrl = ucode(upc_ff);

   always_comb begin
      case (flags.op)
         FN_ENQUEUE:         dispatch = flags.full ? U_RSP_OVFL : U_ENQ;
         FN_DEQUEUE, FN_PEEK: dispatch = flags.empty ? U_RSP_UNDR : U_SCAN0;
         default:            dispatch = U_RSP_ZERO;
      endcase
   end

   always_comb begin
      case (ctrl.cond)
         C_NEXT:      taken = 1'b0;
         C_ALWAYS:    taken = 1'b1;
         C_DISPATCH:  taken = 1'b1;
         C_IDX_NZERO: taken = !flags.idx_zero;
         C_IDX_NLAST: taken = !flags.idx_last;
         C_PEEK:      taken = flags.is_peek;
         C_BEST_LAST: taken = flags.best_last;
         default:     taken = 1'b0;
      endcase
   end

   assign stall = (ctrl.rsp_sel != RS_NONE) && !flags.rsp_free;

   always_comb begin
      if (stall) begin
         upc_in = upc_ff;
      end else if (ctrl.cond == C_DISPATCH) begin
         upc_in = flags.accept ? dispatch : U_IDLE;
      end else if (taken) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = UPC_W'(upc_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== src/pqs_dpath.sv =====
module pqs_dpath import pqs_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctrl_type    ctrl,
   input  logic        req_accept,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_item_value,
   input  logic [7:0]  req_item_priority,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_value,
   output logic [7:0]  rsp_out_priority,
   output flags_type   flags
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [IW-1:0] rd_idx_ff;
   logic [IW-1:0] best_idx_ff;
   entry_type     best_ff;
   logic          first_ff;
   logic [1:0]    op_ff;
   entry_type     item_ff;
   logic [IW-1:0] count_m1;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   entry_type     rd_data;
   logic          take;
   logic          rsp_free;
   logic          rsp_load;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [15:0]   rsp_value_ff;
   logic [7:0]    rsp_priority_ff;

   assign count_m1 = IW'(count_ff - CW'(1));

   pqs_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_data = item_ff;
      case (ctrl.wr_op)
         WR_ENQ: begin
            wr_en = 1'b1;
         end
         WR_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_ff - IW'(1);
            wr_data = rd_data;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      case (ctrl.addr_op)
         A_LAST:      addr_in = count_m1;
         A_DEC:       addr_in = addr_ff - IW'(1);
         A_INC:       addr_in = addr_ff + IW'(1);
         A_BEST_NEXT: addr_in = best_idx_ff + IW'(1);
         default:     addr_in = addr_ff;
      endcase
   end

   always_comb begin
      case (ctrl.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   // newest first, strict greater keeps the newest among equals
   assign take = (ctrl.cmp_op == CMP_SCAN) && (first_ff || rd_data.prio > best_ff.prio);

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (ctrl.rsp_sel != RS_NONE) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      if (req_accept) begin
         op_ff          <= req_func;
         item_ff.value  <= req_item_value;
         item_ff.prio   <= req_item_priority;
      end
      if (ctrl.cmp_op == CMP_INIT) begin
         first_ff <= 1'b1;
      end else if (ctrl.cmp_op == CMP_SCAN) begin
         first_ff <= 1'b0;
      end
      if (take) begin
         best_ff     <= rd_data;
         best_idx_ff <= rd_idx_ff;
      end
      if (rsp_load) begin
         case (ctrl.rsp_sel)
            RS_BEST: begin
               rsp_status_ff   <= ST_OK;
               rsp_value_ff    <= best_ff.value;
               rsp_priority_ff <= best_ff.prio;
            end
            RS_UNDR: begin
               rsp_status_ff   <= ST_UNDERFLOW;
               rsp_value_ff    <= '0;
               rsp_priority_ff <= '0;
            end
            RS_OVFL: begin
               rsp_status_ff   <= ST_OVERFLOW;
               rsp_value_ff    <= '0;
               rsp_priority_ff <= '0;
            end
            default: begin
               rsp_status_ff   <= ST_OK;
               rsp_value_ff    <= '0;
               rsp_priority_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_priority_ff;

   always_comb begin
      flags.accept    = req_accept;
      flags.op        = req_func;
      flags.full      = (count_ff == CW'(CAPACITY));
      flags.empty     = (count_ff == '0);
      flags.idx_zero  = (rd_idx_ff == '0);
      flags.idx_last  = (rd_idx_ff == count_m1);
      flags.best_last = (best_idx_ff == count_m1);
      flags.is_peek   = (op_ff == FN_PEEK);
      flags.rsp_free  = rsp_free;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_op == WR_SHIFT |-> CW'(wr_addr) < count_ff)
      else $error("shift writes past the live entries");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(reset) || $past(ctrl.cnt_op) != CNT_NONE)
      else $error("entry count moved outside an enqueue or dequeue step");

endmodule
